/* design/lbpg_pkg.sv */
// Shared types and constants for the LED blink pattern generator.
package lbpg_pkg;

    localparam int SECTION_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF     = 32;
    localparam int EDGE_BITS         = 18;
    localparam int S_TDATA_W         = 128;
    localparam int M_TDATA_W         = 8;

    typedef enum logic [3:0] {
        OP_TICK         = 4'd0,
        OP_ON           = 4'd1,
        OP_OFF          = 4'd2,
        OP_TOGGLE       = 4'd3,
        OP_BLINK        = 4'd4,
        OP_BLINK_COUNT  = 4'd5,
        OP_TIMED_LEVEL  = 4'd6,
        OP_TIMED_TOGGLE = 4'd7,
        OP_LOAD_SECTION = 4'd8,
        OP_PLAY         = 4'd9,
        OP_STOP         = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        MODE_MANUAL  = 2'd0,
        MODE_BLINK   = 2'd1,
        MODE_COUNTED = 2'd2,
        MODE_SEQ     = 2'd3
    } mode_t;

    typedef struct packed {
        logic [3:0]  operation;
        logic [31:0] on_duration;
        logic [31:0] off_duration;
        logic [15:0] repeat_count;
        logic        start_level;
        logic [3:0]  section_index;
        logic        section_level;
        logic [31:0] section_duration;
        logic [4:0]  sequence_length;
    } item_t;

    typedef struct packed {
        logic  logical_level;
        logic  pin_level;
        mode_t mode;
    } result_t;

endpackage

/* design/lbpg_stage.sv */
// Single-entry pipeline register with valid/ready handshake.
module lbpg_stage #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [WIDTH-1:0] s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // take a new beat when empty or when the held beat leaves this cycle
    assign s_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

/* design/lbpg_core.sv */
// Pattern state, section table and next-state logic for one command or tick.
module lbpg_core
    import lbpg_pkg::*;
#(
    parameter int SECTION_SLOTS = SECTION_SLOTS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cfg_wr_en,
    input  logic    cfg_wr_data,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    localparam int POS_W = (SECTION_SLOTS > 1) ? $clog2(SECTION_SLOTS) : 1;
    localparam int LEN_W = $clog2(SECTION_SLOTS + 1);

    logic                 polarity_reg;
    logic                 level_reg,     level_next;
    mode_t                mode_reg,      mode_next;
    logic                 phase_on_reg,  phase_on_next;
    logic [TIME_BITS-1:0] high_reg,      high_next;
    logic [TIME_BITS-1:0] low_reg,       low_next;
    logic [TIME_BITS-1:0] elapsed_reg,   elapsed_next;
    logic [EDGE_BITS-1:0] edges_reg,     edges_next;
    logic [LEN_W-1:0]     len_reg,       len_next;
    logic [POS_W-1:0]     pos_reg,       pos_next;
    logic [15:0]          repeats_reg,   repeats_next;
    logic [TIME_BITS-1:0] wait_reg,      wait_next;

    logic [TIME_BITS:0]   sect_mem [SECTION_SLOTS];
    logic [TIME_BITS:0]   sect_rd_reg;
    logic [TIME_BITS:0]   sect_wr_data;
    logic [POS_W-1:0]     sect_wr_addr;
    logic                 sect_we;

    op_t                  op;
    logic [TIME_BITS-1:0] on_d;
    logic [TIME_BITS-1:0] off_d;
    logic [TIME_BITS-1:0] elapsed_inc;

    assign op          = op_t'(item.operation);
    assign on_d        = TIME_BITS'(item.on_duration);
    assign off_d       = TIME_BITS'(item.off_duration);
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    assign sect_we      = step && (op == OP_LOAD_SECTION) &&
                          (32'(item.section_index) < 32'(SECTION_SLOTS));
    assign sect_wr_addr = POS_W'(item.section_index);
    assign sect_wr_data = {item.section_level, TIME_BITS'(item.section_duration)};

    always_comb begin
        logic [TIME_BITS-1:0] limit;
        logic [LEN_W-1:0]     pos_inc;
        logic                 st;

        level_next    = level_reg;
        mode_next     = mode_reg;
        phase_on_next = phase_on_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        elapsed_next  = elapsed_reg;
        edges_next    = edges_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        repeats_next  = repeats_reg;
        wait_next     = wait_reg;
        limit         = phase_on_reg ? high_reg : low_reg;
        pos_inc       = LEN_W'(pos_reg) + 1'b1;
        st            = (op == OP_TIMED_TOGGLE) ? !level_reg : item.start_level;

        if (step) begin
            unique case (op)
                OP_TICK: begin
                    if (mode_reg == MODE_BLINK || mode_reg == MODE_COUNTED) begin
                        if (limit > elapsed_inc) begin
                            elapsed_next = elapsed_inc;
                        end else begin
                            level_next    = !phase_on_reg;
                            phase_on_next = !phase_on_reg;
                            elapsed_next  = '0;
                            edges_next    = edges_reg - 1'b1;
                            if (mode_reg == MODE_COUNTED && edges_reg == EDGE_BITS'(1)) begin
                                mode_next = MODE_MANUAL;
                            end
                        end
                    end else if (mode_reg == MODE_SEQ) begin
                        if (wait_reg > elapsed_inc) begin
                            elapsed_next = elapsed_inc;
                        end else begin
                            // sect_rd_reg already holds the section at pos_reg
                            elapsed_next = '0;
                            level_next   = sect_rd_reg[TIME_BITS];
                            wait_next    = sect_rd_reg[TIME_BITS-1:0];
                            if (pos_inc >= len_reg) begin
                                pos_next = '0;
                                if (repeats_reg != '0) begin
                                    repeats_next = repeats_reg - 1'b1;
                                    if (repeats_reg == 16'd1) begin
                                        mode_next = MODE_MANUAL;
                                    end
                                end
                            end else begin
                                pos_next = POS_W'(pos_inc);
                            end
                        end
                    end
                end
                OP_ON: begin
                    mode_next  = MODE_MANUAL;
                    level_next = 1'b1;
                end
                OP_OFF: begin
                    mode_next  = MODE_MANUAL;
                    level_next = 1'b0;
                end
                OP_TOGGLE: begin
                    level_next = !level_reg;
                end
                OP_BLINK: begin
                    // ignore a repeat of the running blink
                    if (!(mode_reg == MODE_BLINK && high_reg == on_d && low_reg == off_d)) begin
                        high_next     = on_d;
                        low_next      = off_d;
                        mode_next     = MODE_BLINK;
                        phase_on_next = item.start_level;
                        level_next    = item.start_level;
                        edges_next    = '1;
                        elapsed_next  = '0;
                    end
                end
                OP_BLINK_COUNT: begin
                    high_next     = on_d;
                    low_next      = off_d;
                    mode_next     = MODE_COUNTED;
                    phase_on_next = item.start_level;
                    level_next    = item.start_level;
                    edges_next    = EDGE_BITS'({item.repeat_count, 1'b0}) - EDGE_BITS'(1)
                                    + EDGE_BITS'(!item.start_level);
                    elapsed_next  = '0;
                end
                OP_TIMED_LEVEL, OP_TIMED_TOGGLE: begin
                    if (st) begin
                        high_next = on_d;
                    end else begin
                        low_next = on_d;
                    end
                    mode_next     = MODE_COUNTED;
                    phase_on_next = st;
                    level_next    = st;
                    edges_next    = EDGE_BITS'(1);
                    elapsed_next  = '0;
                end
                OP_PLAY: begin
                    if (item.sequence_length != '0) begin
                        mode_next    = MODE_SEQ;
                        len_next     = (32'(item.sequence_length) > 32'(SECTION_SLOTS)) ?
                                       LEN_W'(SECTION_SLOTS) : LEN_W'(item.sequence_length);
                        repeats_next = item.repeat_count;
                        elapsed_next = '0;
                        pos_next     = '0;
                        wait_next    = '0;
                    end
                end
                OP_STOP: begin
                    if (mode_reg == MODE_SEQ) begin
                        mode_next = MODE_MANUAL;
                    end
                end
                default: begin
                    // load_section writes the table only; unknown codes do nothing
                end
            endcase
        end
    end

    assign result.logical_level = level_next;
    assign result.pin_level     = level_next ^ polarity_reg;
    assign result.mode          = mode_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polarity_reg <= 1'b0;
            level_reg    <= 1'b0;
            mode_reg     <= MODE_MANUAL;
            phase_on_reg <= 1'b1;
            high_reg     <= '0;
            low_reg      <= '0;
            elapsed_reg  <= '0;
            edges_reg    <= '1;
            len_reg      <= '0;
            pos_reg      <= '0;
            repeats_reg  <= '0;
            wait_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                polarity_reg <= cfg_wr_data;
            end
            level_reg    <= level_next;
            mode_reg     <= mode_next;
            phase_on_reg <= phase_on_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            elapsed_reg  <= elapsed_next;
            edges_reg    <= edges_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            repeats_reg  <= repeats_next;
            wait_reg     <= wait_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sect_we) begin
            sect_mem[sect_wr_addr] <= sect_wr_data;
        end
    end

    // prefetch the section at the next position; forward a same-cycle write
    always_ff @(posedge aclk) begin
        if (sect_we && sect_wr_addr == pos_next) begin
            sect_rd_reg <= sect_wr_data;
        end else begin
            sect_rd_reg <= sect_mem[pos_next];
        end
    end

`ifndef NO_ASSERTIONS
    a_on_sets_manual_high: assert property (@(posedge aclk) disable iff (!aresetn)
        step && op == OP_ON |=> mode_reg == MODE_MANUAL && level_reg)
        else $error("on command did not leave manual high");

    a_play_enters_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        step && op == OP_PLAY && item.sequence_length != '0 |=> mode_reg == MODE_SEQ)
        else $error("play did not enter sequence mode");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_SEQ |-> LEN_W'(pos_reg) < len_reg)
        else $error("table position beyond sequence length");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step && aresetn |=> $stable(level_reg) && $stable(mode_reg) && $stable(elapsed_reg))
        else $error("state changed without a beat");
`endif

endmodule

/* design/led_blink_pattern_generator.sv */
// Top level of the LED blink pattern generator: stream ports and pipeline.
//
// Each beat on the s_ side is one command or one time tick; for every beat one
// result beat (logical level, pin level, mode) appears on the m_ side. A beat
// passes an input register, then one step of the pattern logic updates the
// state and loads the result register, so the block accepts one beat per
// clock while m_ is not stalled. Each result reaches m_ through the input
// register and then the result register. The section table is a
// SECTION_SLOTS-entry memory whose next entry is prefetched each cycle, so
// playback keeps the full rate. Slots are undefined until loaded.
// cfg_wr_en/cfg_wr_data set the output polarity and may be written only
// while no beat is in flight.
module led_blink_pattern_generator
    import lbpg_pkg::*;
#(
    parameter int SECTION_SLOTS = SECTION_SLOTS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] on_duration, [63:32] off_duration, [79:64] repeat_count,
    // [80] start_level, [84:81] section_index, [85] section_level,
    // [117:86] section_duration, [122:118] sequence_length, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [3:0] operation
    input  logic [3:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] logical_level, [1] pin_level, [3:2] mode, rest zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    item_t   in_item;
    item_t   held_item;
    result_t step_result;
    result_t out_result;
    logic    held_valid;
    logic    out_ready;
    logic    step;

    always_comb begin
        in_item.operation        = s_tuser;
        in_item.on_duration      = s_tdata[31:0];
        in_item.off_duration     = s_tdata[63:32];
        in_item.repeat_count     = s_tdata[79:64];
        in_item.start_level      = s_tdata[80];
        in_item.section_index    = s_tdata[84:81];
        in_item.section_level    = s_tdata[85];
        in_item.section_duration = s_tdata[117:86];
        in_item.sequence_length  = s_tdata[122:118];
    end

    lbpg_stage #(
        .WIDTH($bits(item_t))
    ) u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_data  (in_item),
        .m_valid (held_valid),
        .m_ready (out_ready),
        .m_data  (held_item)
    );

    // advance the pattern state when the held beat moves into the result register
    assign step = held_valid && out_ready;

    lbpg_core #(
        .SECTION_SLOTS (SECTION_SLOTS),
        .TIME_BITS     (TIME_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .item        (held_item),
        .result      (step_result)
    );

    lbpg_stage #(
        .WIDTH($bits(result_t))
    ) u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (held_valid),
        .s_ready (out_ready),
        .s_data  (step_result),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (out_result)
    );

    assign m_tdata = {4'b0000, out_result.mode, out_result.pin_level,
                      out_result.logical_level};

endmodule

/* tb/sv/tb_led_blink_pattern_generator.sv */
// Self-checking stream testbench for the LED blink pattern generator.
`timescale 1ns / 100ps

module tb_led_blink_pattern_generator;
    import lbpg_pkg::*;

    localparam int          SLOTS          = SECTION_SLOTS_DEF;
    localparam int          PHASES         = 4;
    localparam int          PHASE_ITEMS    = 475;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          IDLE_PERCENT   = 26;
    localparam logic [3:0]  OP_UNUSED      = 4'hF;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } row_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [3:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // pattern state mirrored from the block
    bit        polarity_q  = 1'b0;
    bit        lvl_q       = 1'b0;
    mode_t     mode_q      = MODE_MANUAL;
    bit        phase_hi_q  = 1'b1;
    bit [31:0] hi_ticks_q  = '0;
    bit [31:0] lo_ticks_q  = '0;
    bit [31:0] elapsed_q   = '0;
    bit [17:0] edges_q     = '1;
    bit        sect_lvl_q [SLOTS];
    bit [31:0] sect_dur_q [SLOTS];
    bit        loaded_q   [SLOTS];
    bit [4:0]  tab_len_q   = '0;
    bit [3:0]  tab_pos_q   = '0;
    bit [15:0] reps_q      = '0;
    bit [31:0] sect_wait_q = '0;

    result_t     due_outputs_q[$];
    row_t        rows_q[$];
    int unsigned miss_count   = 0;
    int unsigned stall_cycles = 0;
    bit          gaps_on      = 1'b1;

    led_blink_pattern_generator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            sect_lvl_q[i] = 1'b0;
            sect_dur_q[i] = '0;
            loaded_q[i]   = 1'b0;
        end
    end

    function automatic result_t outcome(input bit l, input bit p, input mode_t m);
        result_t r;
        r.logical_level = l;
        r.pin_level     = p;
        r.mode          = m;
        return r;
    endfunction

    function automatic void launch_engine(input mode_t m, input bit st, input bit [17:0] edges);
        mode_q     = m;
        phase_hi_q = st;
        lvl_q      = st;
        edges_q    = edges;
        elapsed_q  = '0;
    endfunction

    // Advance the mirrored state by one accepted beat and return the new outputs.
    function automatic result_t advance_pattern(input item_t it);
        bit [31:0] lim;
        bit [17:0] edges;
        bit [4:0]  len;
        int        pos;
        bit        st;
        st = it.start_level;
        case (it.operation)
            OP_TICK: begin
                if (mode_q == MODE_BLINK || mode_q == MODE_COUNTED) begin
                    lim = phase_hi_q ? hi_ticks_q : lo_ticks_q;
                    if (elapsed_q != '1) elapsed_q++;
                    if (lim <= elapsed_q) begin
                        lvl_q      = !phase_hi_q;
                        phase_hi_q = lvl_q;
                        elapsed_q  = '0;
                        edges_q    = edges_q - 18'd1;
                        if (mode_q == MODE_COUNTED && edges_q == '0) mode_q = MODE_MANUAL;
                    end
                end else if (mode_q == MODE_SEQ) begin
                    if (elapsed_q != '1) elapsed_q++;
                    if (sect_wait_q <= elapsed_q) begin
                        elapsed_q   = '0;
                        pos         = tab_pos_q;
                        lvl_q       = sect_lvl_q[pos];
                        sect_wait_q = sect_dur_q[pos];
                        pos++;
                        // wrap the table and count down the repeats
                        if (pos >= tab_len_q) begin
                            pos = 0;
                            if (reps_q != '0) begin
                                reps_q--;
                                if (reps_q == '0) mode_q = MODE_MANUAL;
                            end
                        end
                        tab_pos_q = 4'(pos);
                    end
                end
            end
            OP_ON: begin
                mode_q = MODE_MANUAL;
                lvl_q  = 1'b1;
            end
            OP_OFF: begin
                mode_q = MODE_MANUAL;
                lvl_q  = 1'b0;
            end
            OP_TOGGLE: lvl_q = !lvl_q;
            OP_BLINK: begin
                if (!(mode_q == MODE_BLINK && hi_ticks_q == it.on_duration
                      && lo_ticks_q == it.off_duration)) begin
                    hi_ticks_q = it.on_duration;
                    lo_ticks_q = it.off_duration;
                    launch_engine(MODE_BLINK, st, '1);
                end
            end
            OP_BLINK_COUNT: begin
                hi_ticks_q = it.on_duration;
                lo_ticks_q = it.off_duration;
                edges      = 18'(it.repeat_count) * 18'd2 - 18'd1 + (st ? 18'd0 : 18'd1);
                launch_engine(MODE_COUNTED, st, edges);
            end
            OP_TIMED_LEVEL, OP_TIMED_TOGGLE: begin
                if (it.operation == OP_TIMED_TOGGLE) st = !lvl_q;
                if (st) hi_ticks_q = it.on_duration;
                else lo_ticks_q = it.on_duration;
                launch_engine(MODE_COUNTED, st, 18'd1);
            end
            OP_LOAD_SECTION: begin
                sect_lvl_q[it.section_index] = it.section_level;
                sect_dur_q[it.section_index] = it.section_duration;
                loaded_q[it.section_index]   = 1'b1;
            end
            OP_PLAY: begin
                if (it.sequence_length != '0) begin
                    len         = (it.sequence_length > SLOTS) ? 5'(SLOTS) : it.sequence_length;
                    mode_q      = MODE_SEQ;
                    tab_len_q   = len;
                    reps_q      = it.repeat_count;
                    elapsed_q   = '0;
                    tab_pos_q   = '0;
                    sect_wait_q = '0;
                end
            end
            OP_STOP: begin
                if (mode_q == MODE_SEQ) mode_q = MODE_MANUAL;
            end
            default: ;
        endcase
        return outcome(lvl_q, lvl_q ^ polarity_q, mode_q);
    endfunction

    function automatic void row(input logic [3:0] op, input logic [31:0] on_d, input logic [31:0] off_d,
                                input logic [15:0] cnt, input logic st, input logic [3:0] idx,
                                input logic sl, input logic [31:0] sd, input logic [4:0] len,
                                input bit typed, input result_t want);
        row_t r;
        r.it.operation        = op;
        r.it.on_duration      = on_d;
        r.it.off_duration     = off_d;
        r.it.repeat_count     = cnt;
        r.it.start_level      = st;
        r.it.section_index    = idx;
        r.it.section_level    = sl;
        r.it.section_duration = sd;
        r.it.sequence_length  = len;
        r.typed               = typed;
        r.want                = want;
        rows_q.push_back(r);
    endfunction

    // Mostly short durations so the engines turn over; now and then a huge one.
    function automatic logic [31:0] pick_time();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85) return 32'($urandom_range(0, 4));
        if (r < 95) return 32'($urandom_range(0, 20));
        return $urandom;
    endfunction

    function automatic item_t random_command();
        item_t       it;
        int unsigned r;
        int unsigned run;
        it.operation        = OP_TICK;
        it.on_duration      = $urandom;
        it.off_duration     = $urandom;
        it.repeat_count     = 16'($urandom);
        it.start_level      = 1'($urandom);
        it.section_index    = 4'($urandom);
        it.section_level    = 1'($urandom);
        it.section_duration = $urandom;
        it.sequence_length  = 5'($urandom);
        r = $urandom_range(0, 99);
        if (r < 50) it.operation = OP_TICK;
        else if (r < 53) it.operation = OP_ON;
        else if (r < 56) it.operation = OP_OFF;
        else if (r < 60) it.operation = OP_TOGGLE;
        else if (r < 66) it.operation = OP_BLINK;
        else if (r < 72) it.operation = OP_BLINK_COUNT;
        else if (r < 76) it.operation = OP_TIMED_LEVEL;
        else if (r < 80) it.operation = OP_TIMED_TOGGLE;
        else if (r < 88) it.operation = OP_LOAD_SECTION;
        else if (r < 94) it.operation = OP_PLAY;
        else if (r < 97) it.operation = OP_STOP;
        else it.operation = 4'($urandom_range(int'(OP_STOP) + 1, int'(OP_UNUSED)));

        // play may only walk slots that have been loaded
        run = 0;
        while (run < SLOTS && loaded_q[run]) run++;
        if (it.operation == OP_PLAY && run == 0) it.operation = OP_LOAD_SECTION;

        case (it.operation)
            OP_BLINK: begin
                it.on_duration  = pick_time();
                it.off_duration = pick_time();
                if ($urandom_range(0, 2) == 0) begin
                    it.on_duration  = hi_ticks_q;
                    it.off_duration = lo_ticks_q;
                end
            end
            OP_BLINK_COUNT: begin
                it.on_duration  = pick_time();
                it.off_duration = pick_time();
                it.repeat_count = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 4));
            end
            OP_TIMED_LEVEL, OP_TIMED_TOGGLE: it.on_duration = pick_time();
            OP_LOAD_SECTION: it.section_duration = pick_time();
            OP_PLAY: begin
                it.repeat_count = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 3));
                if ($urandom_range(0, 15) == 0) it.sequence_length = '0;
                else if (run == SLOTS && $urandom_range(0, 3) == 0)
                    it.sequence_length = 5'($urandom_range(SLOTS, 31));
                else it.sequence_length = 5'($urandom_range(1, run));
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_beat(input item_t it, input bit typed, input result_t want);
        logic [S_TDATA_W-1:0] d;
        result_t              pred;
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        d           = '0;
        d[31:0]     = it.on_duration;
        d[63:32]    = it.off_duration;
        d[79:64]    = it.repeat_count;
        d[80]       = it.start_level;
        d[84:81]    = it.section_index;
        d[85]       = it.section_level;
        d[117:86]   = it.section_duration;
        d[122:118]  = it.sequence_length;
        s_tvalid   <= 1'b1;
        s_tdata    <= d;
        s_tuser    <= it.operation;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = advance_pattern(it);
        due_outputs_q.push_back(typed ? want : pred);
    endtask

    // Hold the sender until every result is back, then let the pipeline settle.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (due_outputs_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_polarity(input bit pol);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pol;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        polarity_q   = pol;
    endtask

    task automatic flag_miss(input string what);
        miss_count++;
        if (miss_count <= 10) $display("mismatch: %s", what);
    endtask

    always @(negedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin : check_outputs
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.logical_level = m_tdata[0];
            got.pin_level     = m_tdata[1];
            got.mode          = mode_t'(m_tdata[3:2]);
            if (due_outputs_q.size() == 0) begin
                flag_miss($sformatf("result beat with nothing due: level %0b pin %0b mode %0d",
                                    got.logical_level, got.pin_level, got.mode));
            end else begin
                want = due_outputs_q.pop_front();
                if (got.logical_level != want.logical_level || got.pin_level != want.pin_level
                    || got.mode != want.mode) begin
                    flag_miss($sformatf({"expected level %0b pin %0b mode %0d, ",
                                         "got level %0b pin %0b mode %0d"},
                                        want.logical_level, want.pin_level, want.mode,
                                        got.logical_level, got.pin_level, got.mode));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        item_t       it;
        int unsigned taken;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_polarity(1'b0);

        row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, outcome(0, 0, MODE_MANUAL));
        row(OP_ON, 0, 0, 0, 0, 0, 0, 0, 0, 1, outcome(1, 1, MODE_MANUAL));
        row(OP_TOGGLE, 0, 0, 0, 0, 0, 0, 0, 0, 1, outcome(0, 0, MODE_MANUAL));
        row(OP_TOGGLE, 0, 0, 0, 0, 0, 0, 0, 0, 1, outcome(1, 1, MODE_MANUAL));
        row(OP_OFF, 0, 0, 0, 0, 0, 0, 0, 0, 1, outcome(0, 0, MODE_MANUAL));
        // unknown code with every field at its top value
        row(OP_UNUSED, '1, '1, '1, 1, '1, 1, '1, '1, 1, outcome(0, 0, MODE_MANUAL));
        row(OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 1, outcome(0, 0, MODE_MANUAL));
        row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, outcome(0, 0, MODE_MANUAL));
        row(OP_BLINK, 1, 0, 0, 1, 0, 0, 0, 0, 1, outcome(1, 1, MODE_BLINK));
        // same durations again: ignored, start level included
        row(OP_BLINK, 1, 0, 0, 0, 0, 0, 0, 0, 1, outcome(1, 1, MODE_BLINK));
        row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_BLINK_COUNT, 0, 0, 1, 0, 0, 0, 0, 0, 1, outcome(0, 0, MODE_COUNTED));
        row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        // zero pulses wraps the edge counter
        row(OP_BLINK_COUNT, 0, 0, 0, 1, 0, 0, 0, 0, 1, outcome(1, 1, MODE_COUNTED));
        row(OP_TIMED_LEVEL, 2, 0, 0, 0, 0, 0, 0, 0, 1, outcome(0, 0, MODE_COUNTED));
        row(OP_TIMED_TOGGLE, 0, 0, 0, 0, 0, 0, 0, 0, 1, outcome(1, 1, MODE_COUNTED));
        row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_LOAD_SECTION, 0, 0, 0, 0, 0, 1, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_LOAD_SECTION, 0, 0, 0, 0, 1, 0, 1, 0, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_PLAY, 0, 0, 1, 0, 0, 0, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_PLAY, 0, 0, 1, 0, 0, 0, 0, 2, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        row(OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, outcome(0, 0, MODE_MANUAL));
        foreach (rows_q[i]) send_beat(rows_q[i].it, rows_q[i].typed, rows_q[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_for_drain();
            write_polarity(!ph[0]);
            gaps_on = (ph != 2);
            taken   = 0;
            while (taken < PHASE_ITEMS) begin
                it = random_command();
                send_beat(it, 1'b0, outcome(0, 0, MODE_MANUAL));
                if (it.operation <= OP_STOP) taken++;
            end
        end

        wait_for_drain();
        if (miss_count == 0 && due_outputs_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* led_blink_pattern_generator.f */
design/lbpg_pkg.sv
design/lbpg_stage.sv
design/lbpg_core.sv
design/led_blink_pattern_generator.sv
tb/sv/tb_led_blink_pattern_generator.sv
